>>> src/bobl_pkg.sv
// ----------------------------------------------------------------------------
// bobl_pkg
// Shared types and codes for the bank of bounded lists.
// ----------------------------------------------------------------------------
package bobl_pkg;

	typedef enum logic [2:0] {
		ACT_CREATE    = 3'd0,
		ACT_APPEND    = 3'd1,
		ACT_DROP_LAST = 3'd2,
		ACT_DROP_VAL  = 3'd3,
		ACT_READ      = 3'd4,
		ACT_READ_SORT = 3'd5,
		ACT_RESIZE    = 3'd6,
		ACT_COUNT     = 3'd7
	} action_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_BAD_POS   = 4'd1,
		ST_BAD_SIZE  = 4'd2,
		ST_EXISTS    = 4'd3,
		ST_NO_MEM    = 4'd4,
		ST_NO_LIST   = 4'd5,
		ST_FULL      = 4'd6,
		ST_EMPTY     = 4'd7,
		ST_NOT_FOUND = 4'd8,
		ST_BAD_NEW   = 4'd9
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,    // waiting for a word
		S_DECODE,  // header checks, single-result actions
		S_SRCH_RD, // drop value: issue read
		S_SRCH_CK, // drop value: compare read data
		S_SHF_RD,  // shift down: issue read
		S_SHF_WR,  // shift down: write one place lower
		S_LD_RD,   // read: issue load into sort buffer
		S_LD_WR,   // read: capture and insert
		S_INS,     // sorted read: one insertion step
		S_EMIT,    // stream buffer
		S_RESP     // single result waiting
	} state_t;

endpackage

>>> src/bank_of_bounded_lists_core.sv
// ----------------------------------------------------------------------------
// bank_of_bounded_lists_core
// Bank of bounded lists of signed words with create, append, drop, read,
// sorted read, resize and count.
// ----------------------------------------------------------------------------
// Usage: the input channel (valid/stall) takes one word: action, list_number,
// amount, data_word. stall stays high while an item is at work and while its
// last result word still waits in the output register. Results go out on the
// output channel (out_valid/out_stall) as status, element, fill_count and
// final_flag; final_flag marks the last word of an item.
// Single-result actions go through decode and the result state to the output
// register. Drop value walks the list through the element RAM: a read and a
// compare per word searched, then a read and a write per word shifted. Reads
// load the list into a word buffer, a read and a capture per word; a sorted
// read also runs one compare-and-move step per insertion shift (up to
// MAX_CAP*(MAX_CAP-1)/2) plus one placing step per word after the first,
// then streams one word per cycle while the output does not stall. The
// single-port element RAM and the insertion comparator set the pace.
// A stalled output holds its word; the sequencer waits. Reset clears all list
// headers; element RAM contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module bank_of_bounded_lists_core #(
	parameter int NUM_LISTS = 10,
	parameter int MAX_CAP   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [3:0]         list_number,
	input  logic signed [7:0]  amount,
	input  logic signed [31:0] data_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         status,
	output logic signed [31:0] element,
	output logic [4:0]         fill_count,
	output logic               final_flag
);
	import bobl_pkg::*;

	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CW = $clog2(MAX_CAP + 1);
	localparam int IW = (MAX_CAP > 1) ? $clog2(MAX_CAP) : 1;
	localparam int DEPTH = NUM_LISTS * MAX_CAP;
	localparam int AW = $clog2(DEPTH);

	// list headers
	logic          present_q [NUM_LISTS];
	logic [CW-1:0] cap_q     [NUM_LISTS];
	logic [CW-1:0] fill_q    [NUM_LISTS];

	// latched item
	action_t            act_q;
	logic [3:0]         num_q;
	logic signed [7:0]  amt_q;
	logic [31:0]        word_q;
	logic [LW-1:0]      li_q;

	state_t state_q, state_d;

	logic [CW-1:0] i_q;   // walk index
	logic [CW-1:0] j_q;   // insertion index
	logic [CW-1:0] n_q;   // fill at start
	logic [31:0]   v_q;   // value being inserted
	logic [31:0]   buf_q [MAX_CAP];

	// output register
	logic          ov_q;
	logic [3:0]    st_q;
	logic [31:0]   el_q;
	logic [4:0]    fc_q;
	logic          fin_q;

	// ram port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata, ram_rdata;

	bobl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// current list header
	logic          cur_present;
	logic [CW-1:0] cur_cap, cur_fill;
	logic [AW-1:0] base;
	assign cur_present = present_q[li_q];
	assign cur_cap     = cap_q[li_q];
	assign cur_fill    = fill_q[li_q];
	assign base        = AW'(li_q) * AW'(MAX_CAP);

	logic bad_pos;
	assign bad_pos = (num_q == 4'd0) || (32'(num_q) > 32'(NUM_LISTS));

	// resize arithmetic
	logic signed [9:0] new_cap;
	assign new_cap = $signed({3'b000, 7'(cur_cap)}) + 10'(amt_q);

	// comparator: signed greater-than for insertion
	logic ins_gt;
	assign ins_gt = $signed(buf_q[IW'(j_q - CW'(1))]) > $signed(v_q);

	// input waits until the previous result word has left
	logic in_take;
	assign in_stall = (state_q != S_IDLE) || ov_q;
	assign in_take = in_valid && !in_stall;
	assign out_valid = ov_q;
	assign status = st_q;
	assign element = el_q;
	assign fill_count = fc_q;
	assign final_flag = fin_q;

	logic out_free;
	assign out_free = !ov_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_take) state_d = S_DECODE;
			S_DECODE: begin
				if (bad_pos || (act_q != ACT_CREATE && !cur_present)) begin
					state_d = S_RESP;
				end else begin
					case (act_q)
						ACT_DROP_VAL: state_d = (cur_fill == '0) ? S_RESP : S_SRCH_RD;
						ACT_READ, ACT_READ_SORT: state_d = (cur_fill == '0) ? S_RESP : S_LD_RD;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_SRCH_RD: state_d = S_SRCH_CK;
			S_SRCH_CK: begin
				if (ram_rdata == word_q) state_d = S_SHF_RD;
				else if (i_q + CW'(1) >= n_q) state_d = S_RESP;
				else state_d = S_SRCH_RD;
			end
			S_SHF_RD: state_d = (i_q + CW'(1) >= n_q) ? S_RESP : S_SHF_WR;
			S_SHF_WR: state_d = S_SHF_RD;
			S_LD_RD: state_d = S_LD_WR;
			S_LD_WR: begin
				if (act_q == ACT_READ_SORT && i_q != '0) state_d = S_INS;
				else if (i_q + CW'(1) >= n_q) state_d = S_EMIT;
				else state_d = S_LD_RD;
			end
			S_INS: begin
				if (!(j_q != '0 && ins_gt)) begin
					state_d = (i_q + CW'(1) >= n_q) ? S_EMIT : S_LD_RD;
				end
			end
			S_EMIT: if (out_free && i_q + CW'(1) >= n_q) state_d = S_IDLE;
			S_RESP: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ram controls
	always_comb begin
		ram_we = 1'b0;
		ram_addr = base + AW'(i_q);
		ram_wdata = ram_rdata;
		case (state_q)
			S_DECODE: begin
				ram_addr = base + AW'(cur_fill);
				ram_wdata = word_q;
				ram_we = !bad_pos && act_q == ACT_APPEND && cur_present &&
					cur_fill < cur_cap && 32'(cur_fill) < 32'(MAX_CAP);
			end
			S_SHF_RD: ram_addr = base + AW'(i_q + CW'(1));
			S_SHF_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			for (int k = 0; k < NUM_LISTS; k++) begin
				present_q[k] <= 1'b0;
				cap_q[k] <= '0;
				fill_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						act_q <= action_t'(action);
						num_q <= list_number;
						amt_q <= amount;
						word_q <= data_word;
						li_q <= LW'(list_number - 4'd1);
					end
				end
				S_DECODE: begin
					i_q <= '0;
					n_q <= cur_fill;
					el_q <= '0;
					fin_q <= 1'b1;
					st_q <= ST_OK;
					fc_q <= 5'(cur_fill);
					if (bad_pos) begin
						st_q <= ST_BAD_POS;
						fc_q <= '0;
					end else if (act_q == ACT_CREATE) begin
						if (amt_q < 8'sd1) begin
							st_q <= ST_BAD_SIZE;
							fc_q <= cur_present ? 5'(cur_fill) : 5'd0;
						end else if (cur_present) st_q <= ST_EXISTS;
						else if (32'(amt_q) > 32'(MAX_CAP)) begin
							st_q <= ST_NO_MEM;
							fc_q <= '0;
						end else begin
							present_q[li_q] <= 1'b1;
							cap_q[li_q] <= CW'(amt_q);
							fill_q[li_q] <= '0;
							fc_q <= '0;
						end
					end else if (!cur_present) begin
						st_q <= ST_NO_LIST;
						fc_q <= '0;
					end else begin
						case (act_q)
							ACT_APPEND: begin
								if (cur_fill >= cur_cap || 32'(cur_fill) >= 32'(MAX_CAP))
									st_q <= ST_FULL;
								else begin
									fill_q[li_q] <= cur_fill + CW'(1);
									fc_q <= 5'(cur_fill + CW'(1));
								end
							end
							ACT_DROP_LAST: begin
								if (cur_fill == '0) st_q <= ST_EMPTY;
								else begin
									fill_q[li_q] <= cur_fill - CW'(1);
									fc_q <= 5'(cur_fill - CW'(1));
								end
							end
							ACT_DROP_VAL: if (cur_fill == '0) st_q <= ST_EMPTY;
							ACT_RESIZE: begin
								if (new_cap < 10'sd1) st_q <= ST_BAD_NEW;
								else if (32'(new_cap) > 32'(MAX_CAP)) st_q <= ST_NO_MEM;
								else begin
									cap_q[li_q] <= CW'(new_cap);
									if (32'(cur_fill) > 32'(new_cap)) begin
										fill_q[li_q] <= CW'(new_cap);
										fc_q <= 5'(new_cap);
									end
								end
							end
							ACT_COUNT: if (cur_fill == '0) st_q <= ST_EMPTY;
							default: ;
						endcase
					end
				end
				S_SRCH_CK: begin
					if (ram_rdata == word_q) begin
						fill_q[li_q] <= n_q - CW'(1);
						fc_q <= 5'(n_q - CW'(1));
					end else begin
						i_q <= i_q + CW'(1);
						if (i_q + CW'(1) >= n_q) st_q <= ST_NOT_FOUND;
					end
				end
				S_SHF_WR: i_q <= i_q + CW'(1);
				S_LD_WR: begin
					buf_q[IW'(i_q)] <= ram_rdata;
					v_q <= ram_rdata;
					j_q <= i_q;
					if (!(act_q == ACT_READ_SORT && i_q != '0)) begin
						i_q <= (i_q + CW'(1) >= n_q) ? '0 : i_q + CW'(1);
					end
				end
				S_INS: begin
					if (j_q != '0 && ins_gt) begin
						buf_q[IW'(j_q)] <= buf_q[IW'(j_q - CW'(1))];
						j_q <= j_q - CW'(1);
					end else begin
						buf_q[IW'(j_q)] <= v_q;
						i_q <= (i_q + CW'(1) >= n_q) ? '0 : i_q + CW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						st_q <= ST_OK;
						el_q <= buf_q[IW'(i_q)];
						fc_q <= 5'(n_q);
						fin_q <= (i_q + CW'(1) >= n_q);
						i_q <= i_q + CW'(1);
					end
				end
				S_RESP: if (out_free) ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> src/bobl_ram.sv
// ----------------------------------------------------------------------------
// bobl_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bobl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed list operations into the list bank and checks
// every result word against a behavioral copy of the bank kept here.
// ----------------------------------------------------------------------------
module testbench;
	import bobl_pkg::*;

	localparam int NUM_LISTS = 10;
	localparam int MAX_CAP   = 16;

	typedef struct packed {
		logic [2:0]         act;
		logic [3:0]         num;
		logic signed [7:0]  amt;
		logic signed [31:0] dw;
	} op_word_t;

	typedef struct packed {
		logic [3:0]         st;
		logic signed [31:0] el;
		logic [4:0]         fill;
		logic               fin;
	} res_word_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         action;
	logic [3:0]         list_number;
	logic signed [7:0]  amount;
	logic signed [31:0] data_word;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         status;
	logic signed [31:0] element;
	logic [4:0]         fill_count;
	logic               final_flag;

	bank_of_bounded_lists_core #(.NUM_LISTS(NUM_LISTS), .MAX_CAP(MAX_CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .list_number(list_number),
		.amount(amount), .data_word(data_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .element(element),
		.fill_count(fill_count), .final_flag(final_flag)
	);

	// bank image
	logic signed [31:0] bank_words [NUM_LISTS][MAX_CAP];
	bit                 bank_live [NUM_LISTS];
	int                 bank_cap [NUM_LISTS];
	int                 bank_fill [NUM_LISTS];

	op_word_t  pending_ops [$];
	res_word_t expected_results [$];
	int        errors;
	bit        stim_done;
	bit        quiet_mode;   // no random idling on either side
	bit        hold_output;  // long receiver hold-off
	int        hold_count;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic res_word_t mk(status_t s, logic signed [31:0] e, int f, bit fin);
		res_word_t r;
		r.st = s; r.el = e; r.fill = f[4:0]; r.fin = fin;
		return r;
	endfunction

	// apply one operation to the bank image and queue its results
	task automatic bank_apply(op_word_t op);
		int li, n, i, j, nc, amt;
		status_t s;
		logic signed [31:0] buf_w [MAX_CAP];
		logic signed [31:0] v;
		amt = op.amt;
		s = ST_OK;
		if (op.num < 1 || op.num > NUM_LISTS) begin
			expected_results.push_back(mk(ST_BAD_POS, 0, 0, 1));
			return;
		end
		li = op.num - 1;
		if (op.act == ACT_CREATE) begin
			if (amt < 1) s = ST_BAD_SIZE;
			else if (bank_live[li]) s = ST_EXISTS;
			else if (amt > MAX_CAP) s = ST_NO_MEM;
			else begin
				bank_live[li] = 1; bank_cap[li] = amt; bank_fill[li] = 0;
			end
			expected_results.push_back(mk(s, 0, bank_live[li] ? bank_fill[li] : 0, 1));
			return;
		end
		if (!bank_live[li]) begin
			expected_results.push_back(mk(ST_NO_LIST, 0, 0, 1));
			return;
		end
		case (action_t'(op.act))
			ACT_APPEND: begin
				if (bank_fill[li] >= bank_cap[li]) s = ST_FULL;
				else begin
					bank_words[li][bank_fill[li]] = op.dw;
					bank_fill[li]++;
				end
			end
			ACT_DROP_LAST: begin
				if (bank_fill[li] == 0) s = ST_EMPTY;
				else bank_fill[li]--;
			end
			ACT_DROP_VAL: begin
				if (bank_fill[li] == 0) s = ST_EMPTY;
				else begin
					s = ST_NOT_FOUND;
					for (i = 0; i < bank_fill[li]; i++)
						if (bank_words[li][i] == op.dw) begin
							for (j = i; j + 1 < bank_fill[li]; j++)
								bank_words[li][j] = bank_words[li][j + 1];
							bank_fill[li]--;
							s = ST_OK;
							break;
						end
				end
			end
			ACT_READ, ACT_READ_SORT: begin
				n = bank_fill[li];
				if (n == 0) begin
					expected_results.push_back(mk(ST_OK, 0, 0, 1));
					return;
				end
				for (i = 0; i < n; i++) buf_w[i] = bank_words[li][i];
				if (op.act == ACT_READ_SORT)
					for (i = 1; i < n; i++) begin
						v = buf_w[i];
						j = i;
						while (j > 0 && buf_w[j - 1] > v) begin
							buf_w[j] = buf_w[j - 1];
							j--;
						end
						buf_w[j] = v;
					end
				for (i = 0; i < n; i++)
					expected_results.push_back(mk(ST_OK, buf_w[i], n, i + 1 == n));
				return;
			end
			ACT_RESIZE: begin
				nc = bank_cap[li] + amt;
				if (nc < 1) s = ST_BAD_NEW;
				else if (nc > MAX_CAP) s = ST_NO_MEM;
				else begin
					bank_cap[li] = nc;
					if (bank_fill[li] > nc) bank_fill[li] = nc;
				end
			end
			default: begin
				if (bank_fill[li] == 0) s = ST_EMPTY;
			end
		endcase
		expected_results.push_back(mk(s, 0, bank_fill[li], 1));
	endtask

	function automatic op_word_t op(action_t a, int n, int amt, logic [31:0] dw);
		op_word_t o;
		o.act = a; o.num = n[3:0]; o.amt = amt[7:0]; o.dw = dw;
		return o;
	endfunction

	function automatic logic [31:0] rand_word(int pool_sel);
		// small pool gives repeats so drop value finds matches
		if (pool_sel < 6) return 32'($signed($urandom_range(0, 6)) - 3);
		return $urandom;
	endfunction

	// stimulus
	initial begin
		int k, n, a, lst;
		stim_done = 0;
		// directed
		pending_ops.push_back(op(ACT_CREATE, 0, 4, 0));
		pending_ops.push_back(op(ACT_COUNT, 15, 0, 0));
		pending_ops.push_back(op(ACT_APPEND, 11, 0, 0));
		pending_ops.push_back(op(ACT_APPEND, 1, 0, 5));
		pending_ops.push_back(op(ACT_CREATE, 1, 0, 0));
		pending_ops.push_back(op(ACT_CREATE, 1, -128, 0));
		pending_ops.push_back(op(ACT_CREATE, 1, 17, 0));
		pending_ops.push_back(op(ACT_CREATE, 1, 127, 0));
		pending_ops.push_back(op(ACT_CREATE, 1, 2, 0));
		pending_ops.push_back(op(ACT_CREATE, 1, 3, 0));
		pending_ops.push_back(op(ACT_COUNT, 1, 0, 0));
		pending_ops.push_back(op(ACT_READ, 1, 0, 0));
		pending_ops.push_back(op(ACT_DROP_LAST, 1, 0, 0));
		pending_ops.push_back(op(ACT_DROP_VAL, 1, 0, 0));
		pending_ops.push_back(op(ACT_APPEND, 1, 0, 32'h7fffffff));
		pending_ops.push_back(op(ACT_APPEND, 1, 0, 32'h80000000));
		pending_ops.push_back(op(ACT_APPEND, 1, 0, 32'hffffffff));
		pending_ops.push_back(op(ACT_APPEND, 1, 0, 0));
		pending_ops.push_back(op(ACT_READ_SORT, 1, 0, 0));
		pending_ops.push_back(op(ACT_DROP_VAL, 1, 0, 1));
		pending_ops.push_back(op(ACT_DROP_VAL, 1, 0, 32'h80000000));
		pending_ops.push_back(op(ACT_RESIZE, 1, -2, 0));
		pending_ops.push_back(op(ACT_RESIZE, 1, -1, 0));
		pending_ops.push_back(op(ACT_RESIZE, 1, 127, 0));
		pending_ops.push_back(op(ACT_RESIZE, 1, 15, 0));
		pending_ops.push_back(op(ACT_CREATE, 10, 16, 0));
		// random, mostly on live lists with in-range numbers
		for (k = 0; k < 105; k++) begin
			n = $urandom_range(0, 99);
			lst = (n < 8) ? $urandom_range(0, 15) : $urandom_range(1, 10);
			a = $urandom_range(0, 99);
			if (a < 10)
				pending_ops.push_back(op(ACT_CREATE, lst,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
						: $urandom_range(1, 16), 0));
			else if (a < 45)
				pending_ops.push_back(op(ACT_APPEND, lst, $urandom_range(0, 255),
					rand_word($urandom_range(0, 9))));
			else if (a < 52)
				pending_ops.push_back(op(ACT_DROP_LAST, lst, 0, $urandom));
			else if (a < 64)
				pending_ops.push_back(op(ACT_DROP_VAL, lst, 0,
					rand_word($urandom_range(0, 9))));
			else if (a < 74)
				pending_ops.push_back(op(ACT_READ, lst, 0, 0));
			else if (a < 84)
				pending_ops.push_back(op(ACT_READ_SORT, lst, 0, 0));
			else if (a < 92)
				pending_ops.push_back(op(ACT_RESIZE, lst,
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 8) - 4, 0));
			else
				pending_ops.push_back(op(ACT_COUNT, lst, 0, 0));
		end
		// fill one list fully and read it back sorted
		pending_ops.push_back(op(ACT_RESIZE, 10, 0, 0));
		for (k = 0; k < 17; k++)
			pending_ops.push_back(op(ACT_APPEND, 10, 0, $urandom));
		pending_ops.push_back(op(ACT_READ_SORT, 10, 0, 0));
		pending_ops.push_back(op(ACT_READ, 10, 0, 0));
		stim_done = 1;
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// idle windows: a quiet stretch, then a long receiver hold-off
	initial begin
		quiet_mode = 0;
		hold_output = 0;
		hold_count = 0;
		wait (arst_n);
		repeat (150) @(posedge clk);
		quiet_mode = 1;
		repeat (200) @(posedge clk);
		quiet_mode = 0;
		hold_output = 1;
		while (hold_count < 200) begin
			@(posedge clk);
			hold_count++;
		end
		hold_output = 0;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		op_word_t nx;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0; list_number <= '0; amount <= '0; data_word <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending_ops.size() > 0 &&
				(quiet_mode || $urandom_range(0, 99) >= 27)) begin
				nx = pending_ops.pop_front();
				bank_apply(nx);
				in_valid <= 1'b1;
				action <= nx.act; list_number <= nx.num;
				amount <= nx.amt; data_word <= nx.dw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b1;
		else out_stall <= hold_output || (!quiet_mode && $urandom_range(0, 99) < 27);
	end

	// result check
	always @(posedge clk) begin
		res_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word status=%0d", status);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (element !== e.el) begin
					$error("element expected %0d actual %0d", e.el, element);
					errors++;
				end
				if (fill_count !== e.fill) begin
					$error("fill_count expected %0d actual %0d", e.fill, fill_count);
					errors++;
				end
				if (final_flag !== e.fin) begin
					$error("final_flag expected %0d actual %0d", e.fin, final_flag);
					errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		errors = 0;
		wait (stim_done && pending_ops.size() == 0);
		@(posedge clk);
		while (in_valid || expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("bank_of_bounded_lists_core: match");
		else
			$display("bank_of_bounded_lists_core: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("bank_of_bounded_lists_core: mismatch");
		$finish;
	end

endmodule
